// ----- rtl/veneer_branch_target_decoder_core_assert.svh -----
// Assertion macros shared by the checker of the veneer branch target decoder.
// No dependencies; include by bare file name inside a module body.
`ifndef VENEER_BRANCH_TARGET_DECODER_CORE_ASSERT_SVH
`define VENEER_BRANCH_TARGET_DECODER_CORE_ASSERT_SVH

// check a property at every edge outside reset
`define VBTD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vbtd assertion failed");

// check a property at every edge, reset included
`define VBTD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("vbtd assertion failed");

`endif

// ----- rtl/vbtd_pkg.sv -----
// Types, opcode patterns and helpers of the veneer branch target decoder.
// No dependencies; used by vbtd_decode, the core and its checker.
package vbtd_pkg;

   localparam int AddrW = 64;
   localparam int WordW = 32;
   localparam int SumW  = AddrW + 2;

   localparam logic [1:0] ISA_A64   = 2'd0;
   localparam logic [1:0] ISA_ARM   = 2'd1;
   localparam logic [1:0] ISA_X64   = 2'd2;
   localparam logic [1:0] ISA_NONE  = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_TARGET = 2'd1;
   localparam logic [1:0] KIND_SLOT   = 2'd2;

   localparam logic CSR_ISA_MODE = 1'b0;
   localparam logic CSR_HIGHEST  = 1'b1;

   localparam logic [WordW-1:0] A64_B_MASK    = 32'hfc00_0000;
   localparam logic [WordW-1:0] A64_B_CODE    = 32'h1400_0000;
   localparam logic [WordW-1:0] A64_ADRP_MASK = 32'h9f00_0000;
   localparam logic [WordW-1:0] A64_ADRP_CODE = 32'h9000_0000;
   localparam logic [WordW-1:0] A64_LDR_MASK  = 32'hffc0_0000;
   localparam logic [WordW-1:0] A64_LDR_CODE  = 32'hf940_0000;
   localparam logic [WordW-1:0] A64_ADD_MASK  = 32'hff80_0000;
   localparam logic [WordW-1:0] A64_ADD_CODE  = 32'h9100_0000;
   localparam logic [WordW-1:0] A64_BR_MASK   = 32'hffff_fc1f;
   localparam logic [WordW-1:0] A64_BR_CODE   = 32'hd61f_0000;
   localparam logic [WordW-1:0] A64_LIT_MASK  = 32'hff00_0000;
   localparam logic [WordW-1:0] A64_LIT_CODE  = 32'h5800_0000;
   localparam logic [3:0]       ARM_B_CODE    = 4'ha;
   localparam logic [4:0]       THB_B16_CODE  = 5'b11100;
   localparam logic [4:0]       THB_BW_CODE   = 5'b11110;
   localparam logic [7:0]       X64_JMP_REL   = 8'he9;
   localparam logic [15:0]      X64_JMP_IND   = 16'h25ff;

   typedef struct packed {
      logic [1:0]       isa_mode;
      logic [AddrW-1:0] highest;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [AddrW-1:0] addr;
   } res_type;

   // exact sum check: a negative offset may not go below zero,
   // a positive one may not pass the highest valid address
   function automatic logic off_ok(input logic [SumW-1:0] sum, input logic neg,
                                   input logic [AddrW-1:0] lim);
      logic ok;
      if (neg) begin
         ok = !sum[SumW-1];
      end else begin
         ok = !sum[SumW-1] && (sum[SumW-2:0] <= {1'b0, lim});
      end
      return ok;
   endfunction

endpackage

// ----- rtl/vbtd_decode.sv -----
// Combinational veneer pattern match and target arithmetic for one request.
// Depends on vbtd_pkg.
module vbtd_decode (
   input  logic [vbtd_pkg::AddrW-1:0] cur,
   input  logic [vbtd_pkg::WordW-1:0] w0,
   input  logic [vbtd_pkg::WordW-1:0] w1,
   input  logic [vbtd_pkg::WordW-1:0] w2,
   input  vbtd_pkg::cfg_type          cfg,
   output vbtd_pkg::res_type          res
);
   import vbtd_pkg::*;

   logic [SumW-1:0] cur_x;
   logic [AddrW-1:0] lim;

   logic            b_hit;
   logic [SumW-1:0] b_off, b_sum;
   logic            adrp_hit, br2, ldr_hit, add_hit;
   logic [4:0]      rn;
   logic [20:0]     imm21;
   logic [SumW-1:0] page_x, pd_off, page_sum, ldr_o, add_o, adrp_o, adrp_sum;
   logic            adrp_ok;
   logic            lit_hit;
   logic [SumW-1:0] lit_off, lit_sum;

   logic [SumW-1:0] code_x;
   logic            arm_hit;
   logic [SumW-1:0] arm_base, arm_off, arm_sum;
   logic [15:0]     h0, h1;
   logic            t16_hit, t32_hit, sb, i1, i2;
   logic [24:0]     imm25;
   logic [SumW-1:0] thb_base, thb_off, thb_sum;

   logic [SumW-1:0] x_end, e9_sum, ff_sum;
   logic            end_ok, e9_hit, ff_hit;
   logic [31:0]     rel, disp;

   assign cur_x = {2'b00, cur};
   assign lim   = cfg.highest;

   // AArch64
   assign b_hit = (w0 & A64_B_MASK) == A64_B_CODE;
   assign b_off = {{38{w0[25]}}, w0[25:0], 2'b00};
   assign b_sum = cur_x + b_off;

   assign adrp_hit = (w0 & A64_ADRP_MASK) == A64_ADRP_CODE;
   assign rn       = w0[4:0];
   assign imm21    = {w0[23:5], w0[30:29]};
   assign br2      = (w2 & A64_BR_MASK) == A64_BR_CODE;
   assign ldr_hit  = ((w1 & A64_LDR_MASK) == A64_LDR_CODE) && (w1[9:5] == rn)
                     && br2 && (w2[9:5] == w1[4:0]);
   assign add_hit  = ((w1 & A64_ADD_MASK) == A64_ADD_CODE) && (w1[4:0] == rn)
                     && (w1[9:5] == rn) && br2 && (w2[9:5] == rn);
   assign page_x   = {2'b00, cur[63:12], 12'h000};
   assign pd_off   = {{33{imm21[20]}}, imm21, 12'h000};
   assign page_sum = page_x + pd_off;
   assign ldr_o    = {51'd0, w1[21:10], 3'b000};
   assign add_o    = w1[22] ? {42'd0, w1[21:10], 12'h000} : {54'd0, w1[21:10]};
   assign adrp_o   = ldr_hit ? ldr_o : add_o;
   assign adrp_sum = page_x + pd_off + adrp_o;
   assign adrp_ok  = off_ok(page_sum, imm21[20], lim) && off_ok(adrp_sum, 1'b0, lim);

   assign lit_hit = ((w0 & A64_LIT_MASK) == A64_LIT_CODE)
                    && ((w1 & A64_BR_MASK) == A64_BR_CODE) && (w1[9:5] == w0[4:0]);
   assign lit_off = {{45{w0[23]}}, w0[23:5], 2'b00};
   assign lit_sum = cur_x + lit_off;

   // ARM and Thumb
   assign code_x   = {2'b00, cur[63:1], 1'b0};
   assign arm_hit  = w0[27:24] == ARM_B_CODE;
   assign arm_base = code_x + SumW'(8);
   assign arm_off  = {{40{w0[23]}}, w0[23:0], 2'b00};
   assign arm_sum  = arm_base + arm_off;

   assign h0      = w0[15:0];
   assign h1      = w0[31:16];
   assign t16_hit = h0[15:11] == THB_B16_CODE;
   assign t32_hit = (h0[15:11] == THB_BW_CODE) && h1[15] && !h1[14] && h1[12];
   assign sb      = h0[10];
   assign i1      = ~(h1[13] ^ sb);
   assign i2      = ~(h1[11] ^ sb);
   assign imm25   = {sb, i1, i2, h0[9:0], h1[10:0], 1'b0};
   assign thb_base = code_x + SumW'(4);
   assign thb_off  = t16_hit ? {{54{h0[10]}}, h0[10:0], 1'b0} : {{41{sb}}, imm25};
   assign thb_sum  = thb_base + thb_off;

   // x64
   assign x_end  = cur_x + SumW'(6);
   assign end_ok = !x_end[AddrW] && (x_end[AddrW-1:0] <= lim);
   assign e9_hit = w0[7:0] == X64_JMP_REL;
   assign ff_hit = w0[15:0] == X64_JMP_IND;
   assign rel    = {w1[7:0], w0[31:8]};
   assign disp   = {w1[15:0], w0[31:16]};
   assign e9_sum = cur_x + SumW'(5) + {{34{rel[31]}}, rel};
   assign ff_sum = x_end + {{34{disp[31]}}, disp};

   always_comb begin
      res.kind = KIND_NONE;
      res.addr = '0;
      unique case (cfg.isa_mode)
         ISA_A64: begin
            if (b_hit) begin
               if (off_ok(b_sum, w0[25], lim)) begin
                  res.kind = KIND_TARGET;
                  res.addr = b_sum[AddrW-1:0];
               end
            end else if (adrp_hit) begin
               if ((ldr_hit || add_hit) && adrp_ok) begin
                  res.kind = ldr_hit ? KIND_SLOT : KIND_TARGET;
                  res.addr = adrp_sum[AddrW-1:0];
               end
            end else if (lit_hit && off_ok(lit_sum, w0[23], lim)) begin
               res.kind = KIND_SLOT;
               res.addr = lit_sum[AddrW-1:0];
            end
         end
         ISA_ARM: begin
            if (!cur[0]) begin
               if (arm_hit && !arm_base[AddrW] && off_ok(arm_sum, w0[23], lim)) begin
                  res.kind = KIND_TARGET;
                  res.addr = arm_sum[AddrW-1:0];
               end
            end else if ((t16_hit || t32_hit) && !thb_base[AddrW]
                         && off_ok(thb_sum, thb_off[SumW-1], lim)) begin
               res.kind = KIND_TARGET;
               res.addr = {thb_sum[AddrW-1:1], 1'b1};
            end
         end
         ISA_X64: begin
            if (end_ok) begin
               if (e9_hit) begin
                  if (off_ok(e9_sum, rel[31], lim)) begin
                     res.kind = KIND_TARGET;
                     res.addr = e9_sum[AddrW-1:0];
                  end
               end else if (ff_hit && off_ok(ff_sum, disp[31], lim)) begin
                  res.kind = KIND_SLOT;
                  res.addr = ff_sum[AddrW-1:0];
               end
            end
         end
         default: begin
            res.kind = KIND_NONE;
            res.addr = '0;
         end
      endcase
   end

endmodule

// ----- rtl/veneer_branch_target_decoder_core.sv -----
// Veneer branch target decoder: request register, decode, result register.
// Path: an accepted request goes to the request register, then the result register; rsp_stall can hold it in either.
// Throughput: one request per cycle while rsp_stall does not hold the pipeline; one result per request.
// Reset (synchronous): pipeline empties, isa_mode = AArch64, limit = all ones.
// Depends on vbtd_pkg and vbtd_decode.
module veneer_branch_target_decoder_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [vbtd_pkg::AddrW-1:0] req_instruction_address,
   input  logic [vbtd_pkg::WordW-1:0] req_code_word0,
   input  logic [vbtd_pkg::WordW-1:0] req_code_word1,
   input  logic [vbtd_pkg::WordW-1:0] req_code_word2,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_result_kind,
   output logic [vbtd_pkg::AddrW-1:0] rsp_resolved_address,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [vbtd_pkg::AddrW-1:0] csr_data
);
   import vbtd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             s1_vld_ff, s1_vld_in;
   logic [AddrW-1:0] s1_addr_ff;
   logic [WordW-1:0] s1_w0_ff, s1_w1_ff, s1_w2_ff;
   logic             out_vld_ff, out_vld_in;
   res_type          out_ff;
   res_type          dec_res;
   logic             out_free, s1_move, req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ISA_MODE: cfg_in.isa_mode = csr_data[1:0];
            CSR_HIGHEST:  cfg_in.highest  = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   assign out_free   = !out_vld_ff || !rsp_stall;
   assign s1_move    = s1_vld_ff && out_free;
   assign req_stall  = s1_vld_ff && !out_free;
   assign req_take   = req_valid && !req_stall;
   assign s1_vld_in  = req_take || (s1_vld_ff && !out_free);
   assign out_vld_in = s1_move || (out_vld_ff && rsp_stall);

   vbtd_decode u_decode (
      .cur (s1_addr_ff),
      .w0  (s1_w0_ff),
      .w1  (s1_w1_ff),
      .w2  (s1_w2_ff),
      .cfg (cfg_ff),
      .res (dec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.isa_mode <= ISA_A64;
         cfg_ff.highest  <= '1;
         s1_vld_ff       <= 1'b0;
         out_vld_ff      <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload: request register loads on take, result register on move; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_addr_ff <= req_instruction_address;
         s1_w0_ff   <= req_code_word0;
         s1_w1_ff   <= req_code_word1;
         s1_w2_ff   <= req_code_word2;
      end
      if (s1_move) begin
         out_ff <= dec_res;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_result_kind      = out_ff.kind;
   assign rsp_resolved_address = out_ff.addr;

endmodule

// ----- rtl/vbtd_checker.sv -----
// Port-level checker for veneer_branch_target_decoder_core, bound to it below.
// Depends on vbtd_pkg and veneer_branch_target_decoder_core_assert.svh.
module vbtd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_result_kind,
   input logic [vbtd_pkg::AddrW-1:0] rsp_resolved_address
);
   import vbtd_pkg::*;
   `include "veneer_branch_target_decoder_core_assert.svh"

   `VBTD_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid)
   `VBTD_ASSERT(a_hold_stalled, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `VBTD_ASSERT(a_none_is_zero, clock, reset,
      rsp_valid && rsp_result_kind == KIND_NONE |-> rsp_resolved_address == '0)
   `VBTD_ASSERT(a_kind_legal, clock, reset,
      rsp_valid |-> (rsp_result_kind == KIND_NONE || rsp_result_kind == KIND_TARGET
                     || rsp_result_kind == KIND_SLOT))
   `VBTD_ASSERT(a_latency, clock, reset,
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)

endmodule

bind veneer_branch_target_decoder_core vbtd_checker u_vbtd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_result_kind      (rsp_result_kind),
   .rsp_resolved_address (rsp_resolved_address)
);

// ----- tb/sv/tb_veneer_branch_target_decoder_core.sv -----
// Self-checking testbench of veneer_branch_target_decoder_core: directed and random requests
// for every instruction set, with a scoreboard class that predicts each decoded target.
// Depends on vbtd_pkg and the core RTL.
module tb_veneer_branch_target_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import vbtd_pkg::*;

   localparam int ITEM_COUNT  = 1000;
   localparam int SEGMENTS    = 10;
   localparam int CYCLE_LIMIT = 100000;

   localparam logic [15:0] BW_SUFFIX_MASK = 16'hd000;
   localparam logic [15:0] BW_SUFFIX_CODE = 16'h9000;

   class branch_target_book;
      logic [1:0]  isa_mode;
      logic [63:0] highest;
      res_type     expected_targets[$];
      int          error_count;

      function new();
         isa_mode    = ISA_A64;
         highest     = '1;
         error_count = 0;
      endfunction

      function void write_reg(logic idx, logic [63:0] data);
         if (idx == CSR_ISA_MODE) begin
            isa_mode = data[1:0];
         end else begin
            highest = data;
         end
      endfunction

      function bit add_offset(logic [63:0] base, logic [63:0] off, output logic [63:0] sum);
         logic [63:0] gap;
         sum = '0;
         if (off[63]) begin
            gap = -off;
            if (gap > base) return 1'b0;
            sum = base - gap;
            return 1'b1;
         end
         if (base > highest || off > highest - base) return 1'b0;
         sum = base + off;
         return 1'b1;
      endfunction

      function bit add_step(logic [63:0] base, logic [63:0] k, output logic [63:0] sum);
         sum = base + k;
         return !(base > ~64'd0 - k);
      endfunction

      function logic [1:0] decode_a64(logic [63:0] pc, logic [31:0] w0, logic [31:0] w1,
                                      logic [31:0] w2, output logic [63:0] sum);
         logic [1:0]  kind;
         logic [4:0]  xn;
         logic [20:0] imm21;
         logic [63:0] off;
         logic [63:0] page;
         kind = KIND_NONE;
         sum  = '0;
         if ((w0 & A64_B_MASK) == A64_B_CODE) begin
            off = {{36{w0[25]}}, w0[25:0], 2'b00};
            if (add_offset(pc, off, sum)) kind = KIND_TARGET;
         end else if ((w0 & A64_ADRP_MASK) == A64_ADRP_CODE) begin
            xn    = w0[4:0];
            imm21 = {w0[23:5], w0[30:29]};
            off   = {{31{imm21[20]}}, imm21, 12'h000};
            if (add_offset({pc[63:12], 12'h000}, off, page)) begin
               if ((w1 & A64_LDR_MASK) == A64_LDR_CODE && w1[9:5] == xn &&
                   (w2 & A64_BR_MASK) == A64_BR_CODE && w2[9:5] == w1[4:0]) begin
                  if (add_offset(page, {49'd0, w1[21:10], 3'd0}, sum)) kind = KIND_SLOT;
               end else if ((w1 & A64_ADD_MASK) == A64_ADD_CODE && w1[4:0] == xn &&
                            w1[9:5] == xn && (w2 & A64_BR_MASK) == A64_BR_CODE &&
                            w2[9:5] == xn) begin
                  off = w1[22] ? {40'd0, w1[21:10], 12'd0} : {52'd0, w1[21:10]};
                  if (add_offset(page, off, sum)) kind = KIND_TARGET;
               end
            end
         end else if ((w0 & A64_LIT_MASK) == A64_LIT_CODE &&
                      (w1 & A64_BR_MASK) == A64_BR_CODE && w1[9:5] == w0[4:0]) begin
            off = {{43{w0[23]}}, w0[23:5], 2'b00};
            if (add_offset(pc, off, sum)) kind = KIND_SLOT;
         end
         return kind;
      endfunction

      function logic [1:0] decode_arm(logic [63:0] pc, logic [31:0] w0,
                                      output logic [63:0] sum);
         logic [1:0]  kind;
         logic [63:0] code;
         logic [63:0] base;
         logic [63:0] off;
         logic [63:0] t;
         logic [15:0] h0;
         logic [15:0] h1;
         logic        s;
         logic        i1;
         logic        i2;
         bit          take;
         kind = KIND_NONE;
         sum  = '0;
         code = {pc[63:1], 1'b0};
         if (!pc[0]) begin
            if (w0[27:24] == ARM_B_CODE && add_step(code, 64'd8, base) &&
                add_offset(base, {{38{w0[23]}}, w0[23:0], 2'b00}, sum)) kind = KIND_TARGET;
         end else begin
            h0   = w0[15:0];
            h1   = w0[31:16];
            take = 1'b1;
            off  = '0;
            if (h0[15:11] == THB_B16_CODE) begin
               off = {{52{h0[10]}}, h0[10:0], 1'b0};
            end else if (h0[15:11] == THB_BW_CODE &&
                         (h1 & BW_SUFFIX_MASK) == BW_SUFFIX_CODE) begin
               s   = h0[10];
               i1  = ~(h1[13] ^ s);
               i2  = ~(h1[11] ^ s);
               off = {{39{s}}, s, i1, i2, h0[9:0], h1[10:0], 1'b0};
            end else begin
               take = 1'b0;
            end
            if (take && add_step(code, 64'd4, base) && add_offset(base, off, t)) begin
               kind = KIND_TARGET;
               sum  = t | 64'd1;
            end
         end
         return kind;
      endfunction

      function logic [1:0] decode_x64(logic [63:0] pc, logic [31:0] w0, logic [31:0] w1,
                                      output logic [63:0] sum);
         logic [1:0]  kind;
         logic [63:0] tail;
         logic [31:0] rel;
         kind = KIND_NONE;
         sum  = '0;
         if (add_step(pc, 64'd6, tail) && tail <= highest) begin
            if (w0[7:0] == X64_JMP_REL) begin
               rel = {w1[7:0], w0[31:8]};
               if (add_offset(pc + 64'd5, {{32{rel[31]}}, rel}, sum)) kind = KIND_TARGET;
            end else if (w0[15:0] == X64_JMP_IND) begin
               rel = {w1[15:0], w0[31:16]};
               if (add_offset(tail, {{32{rel[31]}}, rel}, sum)) kind = KIND_SLOT;
            end
         end
         return kind;
      endfunction

      function void note_request(logic [63:0] pc, logic [31:0] w0, logic [31:0] w1,
                                 logic [31:0] w2);
         res_type r;
         r = '0;
         case (isa_mode)
            ISA_A64: r.kind = decode_a64(pc, w0, w1, w2, r.addr);
            ISA_ARM: r.kind = decode_arm(pc, w0, r.addr);
            ISA_X64: r.kind = decode_x64(pc, w0, w1, r.addr);
            default: r.kind = KIND_NONE;
         endcase
         if (r.kind == KIND_NONE) r.addr = '0;
         expected_targets.insert(expected_targets.size(), r);
      endfunction

      function void check_response(logic [1:0] kind, logic [63:0] addr);
         res_type r;
         if (expected_targets.size() == 0) begin
            $error("unexpected result: result_kind %0d resolved_address %h", kind, addr);
            error_count++;
            return;
         end
         r = expected_targets.pop_front();
         if (kind !== r.kind) begin
            $error("result_kind expected %0d actual %0d", r.kind, kind);
            error_count++;
         end
         if (addr !== r.addr) begin
            $error("resolved_address expected %h actual %h", r.addr, addr);
            error_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_instruction_address = '0;
   logic [31:0] req_code_word0 = '0;
   logic [31:0] req_code_word1 = '0;
   logic [31:0] req_code_word2 = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [63:0] rsp_resolved_address;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [63:0] csr_data = '0;

   int send_idle_pct = 36;
   int recv_idle_pct = 46;
   int cycle_count = 0;

   branch_target_book book;

   veneer_branch_target_decoder_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_instruction_address(req_instruction_address),
      .req_code_word0       (req_code_word0),
      .req_code_word1       (req_code_word1),
      .req_code_word2       (req_code_word2),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_resolved_address (rsp_resolved_address),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_veneer_branch_target_decoder_core: FAIL");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            book.check_response(rsp_result_kind, rsp_resolved_address);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_request(logic [63:0] pc, logic [31:0] w0, logic [31:0] w1,
                               logic [31:0] w2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_instruction_address <= pc;
      req_code_word0          <= w0;
      req_code_word1          <= w1;
      req_code_word2          <= w2;
      do @(posedge clock); while (req_stall);
      book.note_request(pc, w0, w1, w2);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.expected_targets.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      book.write_reg(idx, data);
   endtask

   task automatic program_regs(logic [1:0] mode, logic [63:0] lim);
      drain_results();
      write_csr(CSR_ISA_MODE, {$urandom, $urandom_range(32'hffff_ffff) & ~32'd3 | mode});
      write_csr(CSR_HIGHEST, lim);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request(logic [1:0] mode);
      logic [63:0] pc;
      logic [63:0] lim;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [4:0]  xn;
      int          pick;
      int          bit_idx;
      lim = book.highest;
      case ($urandom_range(4))
         0: pc = {$urandom, $urandom};
         1: pc = 64'($urandom_range(65535));
         2: pc = lim - 64'($urandom_range(4095));
         3: pc = ~64'd0 - 64'($urandom_range(4095));
         default: pc = {32'd0, $urandom};
      endcase
      w0   = $urandom;
      w1   = $urandom;
      w2   = $urandom;
      xn   = 5'($urandom_range(31));
      pick = $urandom_range(9);
      case (mode)
         ISA_A64: begin
            if (pick < 2) begin
               w0 = A64_B_CODE | (w0 & ~A64_B_MASK);
            end else if (pick < 6) begin
               w0 = A64_ADRP_CODE | ({w0[31:5], xn} & ~A64_ADRP_MASK);
               if (pick < 4) begin
                  w1      = A64_LDR_CODE | (w1 & ~A64_LDR_MASK);
                  w1[9:5] = xn;
                  w2      = A64_BR_CODE | {22'd0, w1[4:0], 5'd0};
               end else begin
                  w1      = A64_ADD_CODE | (w1 & ~A64_ADD_MASK);
                  w1[9:5] = xn;
                  w1[4:0] = xn;
                  w2      = A64_BR_CODE | {22'd0, xn, 5'd0};
               end
            end else if (pick < 8) begin
               w0 = A64_LIT_CODE | (w0 & ~A64_LIT_MASK);
               w1 = A64_BR_CODE | {22'd0, w0[4:0], 5'd0};
            end
         end
         ISA_ARM: begin
            if (pick < 3) begin
               w0[27:24] = ARM_B_CODE;
            end else if (pick < 6) begin
               w0[15:11] = THB_B16_CODE;
            end else if (pick < 9) begin
               w0[15:11] = THB_BW_CODE;
               w0[31:16] = (w0[31:16] & ~BW_SUFFIX_MASK) | BW_SUFFIX_CODE;
            end
         end
         ISA_X64: begin
            if (pick < 4) begin
               w0[7:0] = X64_JMP_REL;
            end else if (pick < 8) begin
               w0[15:0] = X64_JMP_IND;
            end
         end
         default: ;
      endcase
      if ($urandom_range(7) == 0) begin
         bit_idx = $urandom_range(31);
         case ($urandom_range(2))
            0: w0[bit_idx] = ~w0[bit_idx];
            1: w1[bit_idx] = ~w1[bit_idx];
            default: w2[bit_idx] = ~w2[bit_idx];
         endcase
      end
      send_request(pc, w0, w1, w2);
   endtask

   initial begin
      logic [1:0]  seg_mode[SEGMENTS];
      logic [63:0] lim;
      seg_mode = '{ISA_A64, ISA_ARM, ISA_X64, ISA_A64, ISA_ARM, ISA_X64, ISA_NONE,
                   ISA_A64, ISA_ARM, ISA_X64};
      book = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(64'h1000, 32'h15ff_ffff, 32'h0, 32'h0);
      send_request(64'h0, 32'h1600_0000, 32'h0, 32'h0);
      send_request(64'h1000_0000, 32'h17ff_ffff, 32'h0, 32'h0);
      send_request(~64'd0, 32'h1400_0001, 32'h0, 32'h0);
      send_request(64'h4000_1234, 32'h9000_0010, 32'hf940_0e11, 32'hd61f_0220);
      send_request(64'h4000_1234, 32'hb000_0010, 32'h917f_fe10, 32'hd61f_0200);
      send_request(64'h4000_1234, 32'h9000_0010, 32'h9180_0210, 32'hd61f_0200);
      send_request(64'h4000_1234, 32'h9000_0010, 32'h9100_0211, 32'hd61f_0200);
      send_request(64'h2000, 32'h5800_0051, 32'hd61f_0220, 32'h0);
      send_request(64'h0, 32'h58ff_fff1, 32'hd61f_0220, 32'h0);
      send_request(64'h0, 32'h0, 32'h0, 32'h0);
      send_request(~64'd0, ~32'd0, ~32'd0, ~32'd0);

      program_regs(ISA_A64, 64'h0);
      send_request(64'h0, 32'h1400_0000, 32'h0, 32'h0);
      send_request(64'h0, 32'h1400_0001, 32'h0, 32'h0);

      program_regs(ISA_ARM, ~64'd0);
      send_request(64'h8000, 32'hea00_0010, 32'h0, 32'h0);
      send_request(64'h8000, 32'h0aff_ffff, 32'h0, 32'h0);
      send_request(64'hffff_ffff_ffff_fff8, 32'hea00_0000, 32'h0, 32'h0);
      send_request(64'h8001, 32'h0000_e7ff, 32'h0, 32'h0);
      send_request(64'h8001, 32'h97ff_f3ff, 32'h0, 32'h0);
      send_request(64'h1, 32'h9000_f400, 32'h0, 32'h0);
      send_request(64'h8001, 32'h0000_4770, 32'h0, 32'h0);

      program_regs(ISA_X64, ~64'd0);
      send_request(64'h40_0000, 32'h0001_00e9, 32'h0, 32'h0);
      send_request(64'h40_0000, 32'hfff0_25ff, 32'h0000_ffff, 32'h0);
      send_request(~64'd0 - 64'd2, 32'h0000_00e9, 32'h0, 32'h0);
      send_request(64'h40_0000, 32'h9090_9090, 32'h9090_9090, 32'h0);

      program_regs(ISA_X64, 64'h1000);
      send_request(64'hffc, 32'h0000_00e9, 32'h0, 32'h0);

      program_regs(ISA_NONE, ~64'd0);
      send_request(64'h1000, 32'h1400_0000, 32'h0, 32'h0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(3))
            0: lim = ~64'd0;
            1: lim = {$urandom, $urandom};
            2: lim = 64'($urandom_range(65535));
            default: lim = {1'b0, 31'($urandom), $urandom};
         endcase
         if (seg == 0) lim = ~64'd0;
         program_regs(seg_mode[seg], lim);
         if (seg < 4) begin
            send_idle_pct = 36;
            recv_idle_pct = 46;
         end else if (seg < 7) begin
            send_idle_pct = 46;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < ITEM_COUNT / SEGMENTS; i++) begin
            random_request(seg_mode[seg]);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (book.expected_targets.size() != 0) begin
         $error("%0d expected results never arrived", book.expected_targets.size());
         book.error_count++;
      end
      if (book.error_count == 0) begin
         $display("tb_veneer_branch_target_decoder_core: PASS");
      end else begin
         $display("tb_veneer_branch_target_decoder_core: FAIL");
      end
      $finish;
   end

endmodule
